// ===== src/rrt_pkg.sv =====
package rrt_pkg;

  localparam int CAPACITY_DEF  = 64;
  localparam int NUM_KINDS_DEF = 4;
  localparam int CNT_W         = 7;
  localparam int ENTRY_W       = 32 * 6 + 3 + 1;

  localparam logic [2:0] OP_ENQUEUE  = 3'd0;
  localparam logic [2:0] OP_MARK     = 3'd1;
  localparam logic [2:0] OP_RELEASE  = 3'd2;
  localparam logic [2:0] OP_CANCEL   = 3'd3;
  localparam logic [2:0] OP_CONTAINS = 3'd4;
  localparam logic [2:0] OP_STATS    = 3'd5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_INVALID  = 2'd1;
  localparam logic [1:0] ST_CONFLICT = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] key_handle;
    logic [31:0] asset_ident;
    logic [2:0]  resource_kind;
    logic [31:0] ticket_id;
    logic [31:0] texture_id;
    logic [31:0] mesh_id;
    logic [31:0] shader_id;
  } rrt_in_t;

  typedef struct packed {
    logic [1:0]  status_code;
    logic        matched;
    logic [6:0]  live_entries;
    logic [6:0]  queued_entries;
    logic [6:0]  retiring_entries;
    logic [63:0] released_sum;
    logic [63:0] released_of_kind;
  } rrt_out_t;

  typedef struct packed {
    logic [31:0] handle;
    logic [31:0] asset;
    logic [2:0]  kind;
    logic [31:0] ticket;
    logic [31:0] texture;
    logic [31:0] mesh;
    logic [31:0] shader;
    logic        retiring;
  } rrt_entry_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture input item, clear scan
    logic scan_rd;   // issue read of scan index
    logic scan_chk;  // compare returned entry
    logic rd_last;   // read last live entry
    logic commit;    // apply update
    logic wr_move;   // write last entry into hit slot
  } rrt_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_done;
    logic found;
    logic need_move;
  } rrt_sts_t;

endpackage

// ===== src/resource_retirement_table.sv =====
// channel | ports                          | payload
// input   | in_valid, in_ready, in_data    | rrt_in_t
// result  | out_valid, out_ready, out_data | rrt_out_t
// The result follows the accept once n entries are scanned (n the live count, or up to
// and including the hit), each read and then checked on the single RAM read port; then
// the last entry is read, the update committed, and a removal moves the last entry
// into the freed slot.
// Reset clears counts and control; table contents stay undefined.
// One item at a time: in_ready drops until the result is taken.
module resource_retirement_table #(
  parameter int CAPACITY  = rrt_pkg::CAPACITY_DEF,
  parameter int NUM_KINDS = rrt_pkg::NUM_KINDS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  rrt_pkg::rrt_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output rrt_pkg::rrt_out_t out_data
);
  import rrt_pkg::*;

  rrt_cmd_t cmd;
  rrt_sts_t sts;

  rrt_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .sts, .cmd
  );

  rrt_datapath #(.CAPACITY(CAPACITY), .NUM_KINDS(NUM_KINDS)) u_dp (
    .clk, .rst_n, .cmd, .sts, .in_item(in_data), .res(out_data)
  );

`ifndef SYNTHESIS
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.scan_rd, cmd.scan_chk, cmd.rd_last, cmd.commit, cmd.wr_move}))
    else $error("overlapping commands");
  a_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_data.live_entries <= 7'(CAPACITY) &&
    out_data.retiring_entries <= out_data.live_entries)
    else $error("count out of range");
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("accept while result pending");
`endif
endmodule

// ===== src/rrt_ram.sv =====
module rrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== src/rrt_datapath.sv =====
module rrt_datapath #(
  parameter int CAPACITY  = rrt_pkg::CAPACITY_DEF,
  parameter int NUM_KINDS = rrt_pkg::NUM_KINDS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  rrt_pkg::rrt_cmd_t cmd,
  output rrt_pkg::rrt_sts_t sts,
  input  rrt_pkg::rrt_in_t  in_item,
  output rrt_pkg::rrt_out_t res
);
  import rrt_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int RD = (CAPACITY > 1) ? CAPACITY : 2;
  localparam int IW = $clog2(CAPACITY + 1);

  rrt_in_t          item_r;
  logic [IW-1:0]    cnt_r, cnt_nxt;
  logic [IW-1:0]    ret_r, ret_nxt;
  logic [IW-1:0]    scan_r;
  logic [AW-1:0]    hit_r;
  logic             found_r;
  rrt_entry_t       hit_e_r;
  logic [63:0]      tot_r, tot_nxt;
  logic [63:0]      kind_r [NUM_KINDS];
  logic [63:0]      kind_nxt [NUM_KINDS];
  logic [1:0]       status_r, status_nxt;

  logic             we;
  logic [AW-1:0]    waddr, raddr;
  rrt_entry_t       wdata, rdata;
  logic [AW-1:0]    rd_idx_r;

  rrt_ram #(.WIDTH(ENTRY_W), .DEPTH(RD)) u_ram (
    .clk, .we, .waddr, .wdata(wdata), .raddr, .rdata(rdata)
  );

  logic key_eq;
  assign key_eq = rdata.handle == item_r.key_handle && rdata.kind == item_r.resource_kind &&
                  rdata.ticket == item_r.ticket_id && rdata.texture == item_r.texture_id &&
                  rdata.mesh == item_r.mesh_id && rdata.shader == item_r.shader_id;

  logic [IW-1:0] last;
  assign last = cnt_r - IW'(1);

  // hold the last entry on the read port through commit for the move
  always_comb begin
    raddr = scan_r[AW-1:0];
    if (cmd.rd_last || cmd.commit) raddr = last[AW-1:0];
  end

  assign sts.scan_done = (scan_r >= cnt_r) || found_r;
  assign sts.found     = found_r;
  assign sts.need_move = found_r && (item_r.opcode == OP_RELEASE ||
                         item_r.opcode == OP_CANCEL) && cnt_r > IW'(1) &&
                         IW'(hit_r) != last;

  logic fits, ht, hx, hm, hs;
  always_comb begin
    ht = item_r.ticket_id != '0; hx = item_r.texture_id != '0;
    hm = item_r.mesh_id != '0;   hs = item_r.shader_id != '0;
    fits = (item_r.resource_kind == 3'd1 && ht && !hx && !hm && !hs) ||
           (item_r.resource_kind == 3'd2 && !ht && hx && !hm && !hs) ||
           (item_r.resource_kind == 3'd3 && !ht && !hx && hm && !hs) ||
           (item_r.resource_kind == 3'd4 && !ht && !hx && !hm && hs);
  end

  always_comb begin
    cnt_nxt = cnt_r; ret_nxt = ret_r; tot_nxt = tot_r; status_nxt = ST_OK;
    for (int k = 0; k < NUM_KINDS; k++) kind_nxt[k] = kind_r[k];
    we = 1'b0; waddr = hit_r;
    wdata = rdata;
    if (cmd.wr_move) begin
      we = 1'b1;
    end else if (cmd.commit) begin
      unique case (item_r.opcode)
        OP_ENQUEUE: begin
          if (item_r.key_handle == '0 || item_r.asset_ident == '0) status_nxt = ST_INVALID;
          else if (!fits) status_nxt = ST_CONFLICT;
          else if (found_r) begin
            status_nxt = (hit_e_r.asset != item_r.asset_ident) ? ST_CONFLICT : ST_OK;
          end else if (cnt_r >= IW'(CAPACITY)) status_nxt = ST_FULL;
          else begin
            we = 1'b1; waddr = cnt_r[AW-1:0];
            wdata = '{item_r.key_handle, item_r.asset_ident, item_r.resource_kind,
                      item_r.ticket_id, item_r.texture_id, item_r.mesh_id,
                      item_r.shader_id, 1'b0};
            cnt_nxt = cnt_r + IW'(1);
          end
        end
        OP_MARK: begin
          if (found_r && !hit_e_r.retiring) begin
            we = 1'b1; wdata = hit_e_r; wdata.retiring = 1'b1;
            ret_nxt = ret_r + IW'(1);
          end
        end
        OP_RELEASE, OP_CANCEL: begin
          if (found_r) begin
            if (hit_e_r.retiring && ret_r != '0) ret_nxt = ret_r - IW'(1);
            cnt_nxt = last;
            if (item_r.opcode == OP_RELEASE) begin
              if (tot_r != '1) tot_nxt = tot_r + 64'd1;
              for (int k = 0; k < NUM_KINDS; k++)
                if (hit_e_r.kind == 3'(k + 1) && kind_r[k] != '1)
                  kind_nxt[k] = kind_r[k] + 64'd1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0; ret_r <= '0; tot_r <= '0; found_r <= 1'b0; scan_r <= '0;
      for (int k = 0; k < NUM_KINDS; k++) kind_r[k] <= '0;
    end else begin
      if (cmd.load) begin
        item_r <= in_item; scan_r <= '0; found_r <= 1'b0;
      end
      if (cmd.scan_rd) begin
        rd_idx_r <= scan_r[AW-1:0];
        scan_r <= scan_r + IW'(1);
      end
      if (cmd.scan_chk && !found_r && key_eq) begin
        found_r <= 1'b1; hit_r <= rd_idx_r; hit_e_r <= rdata;
      end
      if (cmd.commit) begin
        cnt_r <= cnt_nxt; ret_r <= ret_nxt; tot_r <= tot_nxt; status_r <= status_nxt;
        for (int k = 0; k < NUM_KINDS; k++) kind_r[k] <= kind_nxt[k];
      end
    end
  end

  logic [63:0] kq;
  always_comb begin
    kq = '0;
    for (int k = 0; k < NUM_KINDS; k++)
      if (item_r.resource_kind == 3'(k + 1)) kq = kind_r[k];
  end

  assign res.status_code      = status_r;
  assign res.matched          = found_r;
  assign res.live_entries     = CNT_W'(cnt_r);
  assign res.queued_entries   = CNT_W'(cnt_r - ret_r);
  assign res.retiring_entries = CNT_W'(ret_r);
  assign res.released_sum     = tot_r;
  assign res.released_of_kind = kq;
endmodule

// ===== src/rrt_ctrl.sv =====
module rrt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  rrt_pkg::rrt_sts_t sts,
  output rrt_pkg::rrt_cmd_t cmd
);
  import rrt_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_READ  = 7'b0000010,
    S_CHECK = 7'b0000100,
    S_LAST  = 7'b0001000,
    S_WAIT  = 7'b0010000,
    S_MOVE  = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic   move_r;

  assign in_ready  = state_r == S_IDLE;
  assign out_valid = state_r == S_OUT;

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid) begin
        cmd.load = 1'b1; state_nxt = S_READ;
      end
      S_READ: begin
        if (sts.scan_done) state_nxt = S_LAST;
        else begin
          cmd.scan_rd = 1'b1; state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.scan_chk = 1'b1; state_nxt = S_READ;
      end
      // read the last entry before the count drops
      S_LAST: begin
        cmd.rd_last = 1'b1; state_nxt = S_WAIT;
      end
      S_WAIT: begin
        cmd.commit = 1'b1;
        state_nxt = move_r ? S_MOVE : S_OUT;
      end
      S_MOVE: begin
        cmd.wr_move = 1'b1; state_nxt = S_OUT;
      end
      S_OUT: if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; move_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_LAST) move_r <= sts.need_move;
    end
  end
endmodule

// ===== test/tb_resource_retirement_table.sv =====
`timescale 1ns / 100ps

module tb_resource_retirement_table;
  import rrt_pkg::*;

  localparam int TABLE_DEPTH = 64;
  localparam int RANDOM_ITEMS = 1750;
  localparam int CYCLE_LIMIT = 2000000;

  class retirement_scoreboard;
    rrt_entry_t  tbl[TABLE_DEPTH];
    int          live_cnt;
    int          retiring_cnt;
    logic [63:0] release_sum;
    logic [63:0] release_by_kind[4];
    rrt_out_t    pending_results[$];
    int          error_cnt;
    int          result_cnt;

    function new();
      live_cnt = 0;
      retiring_cnt = 0;
      release_sum = '0;
      for (int i = 0; i < 4; i++) release_by_kind[i] = '0;
      error_cnt = 0;
      result_cnt = 0;
    endfunction

    function void drop_entry(int idx);
      if (tbl[idx].retiring) retiring_cnt--;
      tbl[idx] = tbl[live_cnt - 1];
      live_cnt--;
    endfunction

    // Apply one accepted item to the table copy and queue its result.
    function void note_input(rrt_in_t d);
      int       hit;
      logic     fits;
      logic     ht, hx, hm, hs;
      rrt_out_t r;
      logic [1:0] st;
      logic [2:0] ek;
      hit = -1;
      st = ST_OK;
      for (int i = 0; i < live_cnt && hit < 0; i++) begin
        if (tbl[i].handle == d.key_handle && tbl[i].kind == d.resource_kind &&
            tbl[i].ticket == d.ticket_id && tbl[i].texture == d.texture_id &&
            tbl[i].mesh == d.mesh_id && tbl[i].shader == d.shader_id)
          hit = i;
      end
      case (d.opcode)
        OP_ENQUEUE: begin
          ht = d.ticket_id != 0;
          hx = d.texture_id != 0;
          hm = d.mesh_id != 0;
          hs = d.shader_id != 0;
          fits = (d.resource_kind == 3'd1 && ht && !hx && !hm && !hs) ||
                 (d.resource_kind == 3'd2 && !ht && hx && !hm && !hs) ||
                 (d.resource_kind == 3'd3 && !ht && !hx && hm && !hs) ||
                 (d.resource_kind == 3'd4 && !ht && !hx && !hm && hs);
          if (d.key_handle == 0 || d.asset_ident == 0) st = ST_INVALID;
          else if (!fits) st = ST_CONFLICT;
          else if (hit >= 0) st = (tbl[hit].asset != d.asset_ident) ? ST_CONFLICT : ST_OK;
          else if (live_cnt >= TABLE_DEPTH) st = ST_FULL;
          else begin
            tbl[live_cnt] = '{d.key_handle, d.asset_ident, d.resource_kind, d.ticket_id,
                              d.texture_id, d.mesh_id, d.shader_id, 1'b0};
            live_cnt++;
          end
        end
        OP_MARK: begin
          if (hit >= 0 && !tbl[hit].retiring) begin
            tbl[hit].retiring = 1'b1;
            retiring_cnt++;
          end
        end
        OP_RELEASE: begin
          if (hit >= 0) begin
            ek = tbl[hit].kind;
            if (ek >= 1 && ek <= 4 && release_by_kind[ek - 1] != '1)
              release_by_kind[ek - 1]++;
            drop_entry(hit);
            if (release_sum != '1) release_sum++;
          end
        end
        OP_CANCEL: begin
          if (hit >= 0) drop_entry(hit);
        end
        default: ;
      endcase
      r.status_code = st;
      r.matched = hit >= 0;
      r.live_entries = 7'(live_cnt);
      r.queued_entries = 7'(live_cnt - retiring_cnt);
      r.retiring_entries = 7'(retiring_cnt);
      r.released_sum = release_sum;
      r.released_of_kind = (d.resource_kind >= 1 && d.resource_kind <= 4) ?
                           release_by_kind[d.resource_kind - 1] : 64'd0;
      pending_results = {pending_results, r};
    endfunction

    task report(string field, logic [63:0] got, logic [63:0] want);
      $display("result %0d: %s got %0h want %0h", result_cnt, field, got, want);
      error_cnt++;
    endtask

    task check_result(rrt_out_t got);
      rrt_out_t want;
      if (pending_results.size() == 0) begin
        report("unexpected item", 64'(got), 64'd0);
      end else begin
        want = pending_results.pop_front();
        if (got.status_code !== want.status_code)
          report("status_code", 64'(got.status_code), 64'(want.status_code));
        if (got.matched !== want.matched)
          report("matched", 64'(got.matched), 64'(want.matched));
        if (got.live_entries !== want.live_entries)
          report("live_entries", 64'(got.live_entries), 64'(want.live_entries));
        if (got.queued_entries !== want.queued_entries)
          report("queued_entries", 64'(got.queued_entries), 64'(want.queued_entries));
        if (got.retiring_entries !== want.retiring_entries)
          report("retiring_entries", 64'(got.retiring_entries),
                 64'(want.retiring_entries));
        if (got.released_sum !== want.released_sum)
          report("released_sum", got.released_sum, want.released_sum);
        if (got.released_of_kind !== want.released_of_kind)
          report("released_of_kind", got.released_of_kind, want.released_of_kind);
      end
      result_cnt++;
    endtask
  endclass

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  rrt_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  rrt_out_t out_data;

  retirement_scoreboard sb;
  logic quiet;
  int   cycle_cnt;

  resource_retirement_table uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("resource_retirement_table: mismatch");
      $finish;
    end
  end

  // Result side: sample the handshake, then pick next cycle's ready.
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) sb.check_result(out_data);
      out_ready <= quiet || ($urandom_range(0, 99) >= 25);
    end
  end

  task send_item(rrt_in_t d);
    int gap;
    gap = (!quiet && $urandom_range(0, 99) < 25) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= d;
    do @(posedge clk); while (!in_ready);
    sb.note_input(d);
  endtask

  function automatic rrt_in_t keyed(logic [2:0] op, logic [31:0] h, logic [31:0] a,
                                    logic [2:0] k, logic [31:0] id);
    rrt_in_t d;
    d = '0;
    d.opcode = op;
    d.key_handle = h;
    d.asset_ident = a;
    d.resource_kind = k;
    case (k)
      3'd1: d.ticket_id = id;
      3'd2: d.texture_id = id;
      3'd3: d.mesh_id = id;
      3'd4: d.shader_id = id;
      default: ;
    endcase
    return d;
  endfunction

  function automatic logic [31:0] pick_word();
    return ($urandom_range(0, 99) < 60) ? 32'($urandom_range(1, 6)) : $urandom;
  endfunction

  function automatic rrt_in_t make_item(int enq_pct);
    rrt_in_t d;
    logic [2:0] op;
    int roll;
    int idx;
    if ($urandom_range(0, 99) < 12) begin
      d = '{3'($urandom), $urandom, $urandom, 3'($urandom), $urandom, $urandom,
            $urandom, $urandom};
      return d;
    end
    roll = $urandom_range(0, 99);
    if (roll < enq_pct) op = OP_ENQUEUE;
    else if (roll >= 97) op = 3'($urandom_range(6, 7));
    else op = 3'($urandom_range(1, 5));
    if (sb.live_cnt > 0 && $urandom_range(0, 99) < 65) begin
      // Reuse a live key so mark, release and duplicates find a hit.
      idx = $urandom_range(0, sb.live_cnt - 1);
      d.opcode = op;
      d.key_handle = sb.tbl[idx].handle;
      d.asset_ident = ($urandom_range(0, 99) < 70) ? sb.tbl[idx].asset : pick_word();
      d.resource_kind = sb.tbl[idx].kind;
      d.ticket_id = sb.tbl[idx].ticket;
      d.texture_id = sb.tbl[idx].texture;
      d.mesh_id = sb.tbl[idx].mesh;
      d.shader_id = sb.tbl[idx].shader;
    end else begin
      d = keyed(op, pick_word(), pick_word(), 3'($urandom_range(1, 4)), pick_word());
    end
    roll = $urandom_range(0, 99);
    if (roll < 3) d.key_handle = '0;
    else if (roll < 6) d.asset_ident = '0;
    else if (roll < 9) d.ticket_id = pick_word();
    else if (roll < 11) d.resource_kind = 3'($urandom_range(0, 7));
    return d;
  endfunction

  initial begin
    int enq_pct;
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    quiet = 1'b0;
    cycle_cnt = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(keyed(OP_STATS, 32'd1, 32'd1, 3'd1, 32'd1));
    send_item(keyed(OP_ENQUEUE, 32'd0, 32'd5, 3'd1, 32'd7));
    send_item(keyed(OP_ENQUEUE, 32'd9, 32'd0, 3'd2, 32'd7));
    send_item(keyed(OP_ENQUEUE, 32'd9, 32'd5, 3'd0, 32'd7));
    send_item(keyed(OP_ENQUEUE, 32'd9, 32'd5, 3'd7, 32'd7));
    send_item({OP_ENQUEUE, 32'd9, 32'd5, 3'd1, 32'd3, 32'd4, 32'd0, 32'd0});
    send_item(keyed(OP_ENQUEUE, 32'd9, 32'd5, 3'd2, 32'd0));
    send_item(keyed(OP_ENQUEUE, '1, '1, 3'd1, '1));
    send_item(keyed(OP_ENQUEUE, '1, 32'd2, 3'd2, '1));
    send_item(keyed(OP_ENQUEUE, 32'd3, 32'd3, 3'd3, 32'd1));
    send_item(keyed(OP_ENQUEUE, 32'd4, 32'd4, 3'd4, '1));
    send_item(keyed(OP_ENQUEUE, '1, '1, 3'd1, '1));
    send_item(keyed(OP_ENQUEUE, '1, 32'd8, 3'd1, '1));
    send_item(keyed(OP_CONTAINS, '1, 32'd0, 3'd2, '1));
    send_item(keyed(OP_MARK, '1, 32'd0, 3'd1, '1));
    send_item(keyed(OP_MARK, '1, 32'd0, 3'd1, '1));
    send_item(keyed(OP_MARK, 32'd77, 32'd0, 3'd1, '1));
    send_item(keyed(OP_RELEASE, '1, 32'd0, 3'd1, '1));
    send_item(keyed(OP_RELEASE, '1, 32'd0, 3'd1, '1));
    send_item(keyed(OP_CANCEL, 32'd3, 32'd0, 3'd3, 32'd1));
    send_item(keyed(OP_CANCEL, 32'd3, 32'd0, 3'd3, 32'd1));
    send_item(keyed(3'd6, 32'd4, 32'd0, 3'd4, '1));
    send_item(keyed(3'd7, 32'd4, 32'd0, 3'd5, '1));

    // Alternate filling and draining phases so the table hits full and empty.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      quiet = (n >= 700 && n < 950);
      enq_pct = ((n / 200) % 2 == 0) ? 75 : 15;
      send_item(make_item(enq_pct));
    end
    in_valid <= 1'b0;
    quiet = 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.error_cnt == 0) begin
      $display("resource_retirement_table: match");
    end else begin
      $display("resource_retirement_table: mismatch");
    end
    $finish;
  end

endmodule
